@@ hdl/sarm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sarm_pkg;

  localparam int unsigned REG_WORDS_DEF = 64;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ADC_W         = 10;
  localparam int unsigned CODE_W        = 11;
  localparam int unsigned CNT_W         = 4;

  localparam int unsigned CTRL_WORD    = 20;
  localparam int unsigned RESULT_WORD  = 32;
  localparam int unsigned RESULT_COUNT = 8;
  localparam int unsigned START_BIT    = 1;
  localparam int unsigned STATE_LSB    = 24;
  localparam int unsigned STATE_MSB    = 26;

  localparam int unsigned CORR_OFS  = 21;
  localparam int unsigned CORR_GAIN = 279;

  typedef struct packed {
    logic accept;
    logic search;
    logic pick;
    logic fill;
    logic clr_state;
  } cmd_t;

  typedef struct packed {
    logic conv_start;
    logic search_last;
    logic pick_last;
    logic fill_last;
  } sts_t;

  // inverted, offset- and gain-corrected decode of one sample code
  function automatic logic [CODE_W-1:0] decode_code(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] inv;
    logic [7:0]        lo;
    logic [16:0]       prod;
    logic [8:0]        shifted;
    logic [7:0]        corr;
    inv     = ~code;
    lo      = inv[7:0];
    prod    = '0;
    shifted = '0;
    corr    = '0;
    if (lo > 8'(CORR_OFS)) begin
      prod    = 17'(lo - 8'(CORR_OFS)) * 17'(CORR_GAIN);
      shifted = prod[16:8];
      corr    = (shifted > 9'd255) ? 8'hFF : shifted[7:0];
    end
    return {inv[10:8], 8'h00} + CODE_W'(corr);
  endfunction

endpackage

`default_nettype wire

@@ hdl/sarm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sarm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output sarm_pkg::cmd_t     cmd_o,
  input  wire sarm_pkg::sts_t sts_i
);
  import sarm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_PICK   = 4'b0100,
    S_FILL   = 4'b1000
  } sarm_state_e;

  sarm_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  assign in_stall_o  = (state_q != S_IDLE) | (out_valid_q & out_stall_i);
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.accept    = accept;
    cmd_o.search    = (state_q == S_SEARCH);
    cmd_o.pick      = (state_q == S_PICK);
    cmd_o.fill      = (state_q == S_FILL);
    cmd_o.clr_state = (state_q == S_FILL) & sts_i.fill_last;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && sts_i.conv_start) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (sts_i.search_last) state_d = S_PICK;
      end
      S_PICK: begin
        if (sts_i.pick_last) state_d = S_FILL;
      end
      S_FILL: begin
        if (sts_i.fill_last) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sarm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sarm_datapath #(
  parameter int unsigned REG_WORDS = sarm_pkg::REG_WORDS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sarm_pkg::cmd_t                cmd_i,
  output sarm_pkg::sts_t                     sts_o,
  input  wire logic                          action_i,
  input  wire logic [sarm_pkg::IDX_W-1:0]    reg_index_i,
  input  wire logic [sarm_pkg::DATA_W-1:0]   write_data_i,
  input  wire logic [sarm_pkg::ADC_W-1:0]    adc_code_i,
  output logic      [sarm_pkg::DATA_W-1:0]   read_data_o,
  output logic                               converted_o
);
  import sarm_pkg::*;

  localparam int unsigned MaxWords = 1 << IDX_W;
  localparam int unsigned Depth    = (REG_WORDS < MaxWords) ? REG_WORDS : MaxWords;
  localparam int unsigned AddrW    = $clog2(Depth);

  logic [DATA_W-1:0] mem [Depth];
  logic [Depth-1:0]  valid_q;
  logic [DATA_W-1:0] rdata_q;
  logic              rd_zero_q, rd_ctrl_q, converted_q;
  logic [DATA_W-1:0] ctrl_q;

  logic [ADC_W-1:0]  adc_q;
  logic [CODE_W-1:0] cnt_q;
  logic [CODE_W-1:0] low_val_q, high_val_q, low_code_q, high_code_q;
  logic [CODE_W-1:0] best_err_q;
  logic [CNT_W-1:0]  best_cnt_q;

  logic              in_range, is_ctrl, conv_start, wr_acc, phase_last;
  logic [AddrW-1:0]  raddr, waddr;
  logic              mem_we;
  logic [DATA_W-1:0] wdata;
  logic [CODE_W-1:0] dec_val, target;
  logic [CNT_W-1:0]  pick_c;
  logic [14:0]       sum, sum_rnd;
  logic [CODE_W-1:0] res, adc_ext, err;

  assign in_range   = 32'(reg_index_i) < REG_WORDS;
  assign is_ctrl    = reg_index_i == IDX_W'(CTRL_WORD);
  assign conv_start = cmd_i.accept & action_i & in_range & is_ctrl
                    & ~ctrl_q[START_BIT] & write_data_i[START_BIT];
  assign wr_acc     = cmd_i.accept & action_i & in_range & ~is_ctrl;
  assign raddr      = reg_index_i[AddrW-1:0];

  assign sts_o.conv_start  = conv_start;
  assign sts_o.search_last = cnt_q == {CODE_W{1'b1}};
  assign sts_o.pick_last   = cnt_q == CODE_W'(RESULT_COUNT);
  assign sts_o.fill_last   = cnt_q == CODE_W'(RESULT_COUNT - 1);
  assign phase_last = (cmd_i.search & sts_o.search_last) | (cmd_i.pick & sts_o.pick_last)
                    | (cmd_i.fill & sts_o.fill_last);

  // code search
  assign dec_val = decode_code(cnt_q);
  assign target  = {adc_q, 1'b0};

  // blend count candidate
  assign pick_c  = cnt_q[CNT_W-1:0];
  assign sum     = 15'(CNT_W'(RESULT_COUNT) - pick_c) * 15'(low_val_q)
                 + 15'(pick_c) * 15'(high_val_q);
  assign sum_rnd = sum + 15'd8;
  assign res     = sum_rnd[14:4];
  assign adc_ext = CODE_W'(adc_q);
  assign err     = (res > adc_ext) ? (res - adc_ext) : (adc_ext - res);

  // result word write, or bus write of a plain word
  assign mem_we = wr_acc | cmd_i.fill;
  assign waddr  = cmd_i.fill ? (AddrW'(RESULT_WORD) + AddrW'(cnt_q[2:0])) : raddr;
  assign wdata  = cmd_i.fill
                ? DATA_W'(({1'b0, cnt_q[2:0]} < best_cnt_q) ? high_code_q : low_code_q)
                : write_data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    if (cmd_i.accept) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_zero_q   <= action_i | ~in_range | (~is_ctrl & ~valid_q[raddr]);
      rd_ctrl_q   <= is_ctrl;
      converted_q <= conv_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (cmd_i.accept && action_i && in_range && is_ctrl) begin
      ctrl_q <= write_data_i;
    end else if (cmd_i.clr_state) begin
      ctrl_q[STATE_MSB:STATE_LSB] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (conv_start || phase_last) begin
      cnt_q <= '0;
    end else if (cmd_i.search || cmd_i.pick || cmd_i.fill) begin
      cnt_q <= cnt_q + CODE_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv_start) begin
      adc_q       <= adc_code_i;
      low_val_q   <= '0;
      low_code_q  <= '0;
      high_val_q  <= {CODE_W{1'b1}};
      high_code_q <= '0;
      best_err_q  <= {CODE_W{1'b1}};
      best_cnt_q  <= '0;
    end else begin
      if (cmd_i.search) begin
        if (dec_val <= target && dec_val >= low_val_q) begin
          low_val_q  <= dec_val;
          low_code_q <= cnt_q;
        end
        if (dec_val >= target && dec_val <= high_val_q) begin
          high_val_q  <= dec_val;
          high_code_q <= cnt_q;
        end
      end
      if (cmd_i.pick && err < best_err_q) begin
        best_err_q <= err;
        best_cnt_q <= pick_c;
      end
    end
  end

  assign read_data_o = rd_zero_q ? '0 : (rd_ctrl_q ? ctrl_q : rdata_q);
  assign converted_o = converted_q;

endmodule

`default_nettype wire

@@ hdl/sar_adc_register_model.sv @@
// Register file of 32-bit words with a built-in code converter. Each bus request (read or
// write of one word index) is taken and its response appears in the output
// register on the next cycle, so plain requests flow at one per cycle while the output is
// taken; read data comes from a word memory with one write port and a registered read port,
// and words never written read as zero. Writing the control word (index 20) so that its start
// bit (bit 1) goes from clear to set launches a conversion of the request's ADC code: the
// request's own response (zero data, converted set) is issued at once, but no further
// request is taken until the sample code search (one code decoded per cycle), the choice
// of the blend count and the writing of result words 32 to 39 through the memory write
// port are done; control bits 24 to 26 clear on the last result write.
`timescale 1ns / 1ps
`default_nettype none

module sar_adc_register_model #(
  parameter int unsigned REG_WORDS = sarm_pkg::REG_WORDS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          action_i,
  input  wire logic [sarm_pkg::IDX_W-1:0]    reg_index_i,
  input  wire logic [sarm_pkg::DATA_W-1:0]   write_data_i,
  input  wire logic [sarm_pkg::ADC_W-1:0]    adc_code_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [sarm_pkg::DATA_W-1:0]   read_data_o,
  output logic                               converted_o
);
  import sarm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sarm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sarm_datapath #(
    .REG_WORDS (REG_WORDS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .action_i     (action_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .adc_code_i   (adc_code_i),
    .read_data_o  (read_data_o),
    .converted_o  (converted_o)
  );

endmodule

`default_nettype wire

@@ hdl/sarm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sarm_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        action_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [sarm_pkg::DATA_W-1:0] read_data_o,
  input wire logic                        converted_o
);
  import sarm_pkg::*;

  logic req_acc;
  assign req_acc = in_valid_i & ~in_stall_o;

  // a write responds with zero data
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && action_i) |=> (out_valid_o && read_data_o == '0))
    else $error("write request did not respond with zero data");

  // a read never reports a conversion
  a_read_noconv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && !action_i) |=> (out_valid_o && !converted_o))
    else $error("read request reported a conversion");

  // a converting write holds off the next request
  a_conv_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc ##1 converted_o |-> in_stall_o)
    else $error("request taken while conversion running");

  // stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(read_data_o) && $stable(converted_o)))
    else $error("stalled response changed");

endmodule

bind sar_adc_register_model sarm_checker u_sarm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o),
  .converted_o (converted_o)
);

`default_nettype wire
